### rtl/surface_normal_jacobian_macros.svh
// Assertion macros for the surface normal and Jacobian block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SURFACE_NORMAL_JACOBIAN_MACROS_SVH
`define SURFACE_NORMAL_JACOBIAN_MACROS_SVH

// same-cycle implication
`define SNJ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SNJ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/snj_pkg.sv
// Package for the surface normal and Jacobian block: widths, stage counts
// and the stage record types. No dependencies.
`default_nettype none
package snj_pkg;

    localparam int TanW     = 16;
    localparam int MagW     = 32;
    localparam int SumW     = 64;
    localparam int RootW    = 32;
    localparam int RemW     = RootW + 3;
    localparam int QuoW     = 15;
    localparam int FracW    = 14;
    localparam int NumW     = MagW + QuoW;
    localparam int JacW     = 24;
    localparam int NormW    = 16;
    localparam int JacShift = 12;
    localparam int SqStages = RootW;
    localparam int DvStages = QuoW;

    localparam logic [1:0] DimsCurve = 2'd1;
    localparam logic [1:0] DimsReset = 2'd2;

    typedef struct packed {
        logic                      curve;
        logic                      last;
        logic [2:0]                neg;
        logic [2:0][MagW-1:0]      mag;
    } side_t;

    typedef struct packed {
        logic [SumW-1:0]           x;
        logic [RemW-1:0]           rem;
        logic [RootW-1:0]          root;
        side_t                     side;
    } sq_t;

    typedef struct packed {
        logic [2:0][NumW-1:0]      rem;
        logic [2:0][QuoW-1:0]      quo;
        logic [RootW-1:0]          den;
        logic [JacW-1:0]           jac;
        logic                      degen;
        logic                      last;
        logic [2:0]                neg;
    } dv_t;

endpackage
`default_nettype wire

### rtl/surface_normal_jacobian.sv
// Top level of the surface normal and Jacobian block.
// Depends on snj_pkg and surface_normal_jacobian_macros.svh.
//
// Takes one quadrature point per cycle while in_stall is low and returns one
// result per point, in order. Products, cross product, squares and sum take
// four stages, the square root resolves one root bit per stage over 32 stages,
// and the three normal divisions resolve one quotient bit per stage over 15
// shared-timing stages, plus a division setup register and an output register.
// The whole pipeline holds while a result waits under stall; bubbles do not
// collapse, so throughput is one point per cycle whenever out_stall is low.
`default_nettype none
`include "surface_normal_jacobian_macros.svh"
module surface_normal_jacobian
    import snj_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [1:0]              cfg_wdata,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [TanW-1:0]  tan0_x,
    input  wire logic signed [TanW-1:0]  tan0_y,
    input  wire logic signed [TanW-1:0]  tan0_z,
    input  wire logic signed [TanW-1:0]  tan1_x,
    input  wire logic signed [TanW-1:0]  tan1_y,
    input  wire logic signed [TanW-1:0]  tan1_z,
    input  wire logic                    point_is_final,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [JacW-1:0]              jacobian,
    output logic signed [NormW-1:0]      normal_x,
    output logic signed [NormW-1:0]      normal_y,
    output logic signed [NormW-1:0]      normal_z,
    output logic                         degenerate,
    output logic                         last_out
);

    localparam int NVld = 4 + SqStages + 1 + DvStages + 1;

    logic [1:0]       dims_reg;
    logic [NVld-1:0]  vld_reg;
    logic             en;

    assign en       = !(vld_reg[NVld-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= DimsReset;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                dims_reg <= cfg_wdata;
            if (en)
                vld_reg <= {vld_reg[NVld-2:0], in_valid};
        end
    end

    // stage 1: products
    logic signed [2*TanW-1:0] p_reg [6];
    logic signed [TanW-1:0]   ax_reg, ay_reg;
    logic                     curve1_reg, last1_reg;

    // stage 2: cross product (rotated tangent in curve mode), split into sign and magnitude
    side_t                    s2_reg;
    logic signed [2*TanW:0]   c_next [3];
    side_t                    s2_next;

    // stage 3: squares
    side_t                    s3_reg;
    logic [SumW-1:0]          sq_reg [3];

    // square-root pipeline, entry 0 is the sum stage
    sq_t                      sq_pipe_reg [SqStages+1];
    sq_t                      sq_pipe_next [SqStages+1];

    // division pipeline, entry 0 is the setup stage
    dv_t                      dv_pipe_reg [DvStages+1];
    dv_t                      dv_pipe_next [DvStages+1];

    logic [RootW-1:0]         m_w;
    side_t                    side_w;

    logic [JacW-1:0]          jac_reg;
    logic signed [NormW-1:0]  nx_reg, ny_reg, nz_reg;
    logic                     degen_reg, last_reg;

    always_comb
    begin
        s2_next.curve = curve1_reg;
        s2_next.last  = last1_reg;
        if (curve1_reg)
        begin
            c_next[0] = (2*TanW+1)'(ay_reg);
            c_next[1] = -((2*TanW+1)'(ax_reg));
            c_next[2] = '0;
        end
        else
        begin
            c_next[0] = (2*TanW+1)'(p_reg[0]) - (2*TanW+1)'(p_reg[1]);
            c_next[1] = (2*TanW+1)'(p_reg[2]) - (2*TanW+1)'(p_reg[3]);
            c_next[2] = (2*TanW+1)'(p_reg[4]) - (2*TanW+1)'(p_reg[5]);
        end
        for (int i = 0; i < 3; i++)
        begin
            s2_next.neg[i] = c_next[i][2*TanW];
            s2_next.mag[i] = c_next[i][2*TanW] ? MagW'(-c_next[i]) : MagW'(c_next[i]);
        end
    end

    always_comb
    begin
        logic [RemW-1:0] r2;
        logic [RemW-1:0] t;
        sq_pipe_next[0] = sq_pipe_reg[0];
        for (int k = 0; k < SqStages; k++)
        begin
            r2 = {sq_pipe_reg[k].rem[RemW-3:0], sq_pipe_reg[k].x[SumW-1 -: 2]};
            t  = {1'b0, sq_pipe_reg[k].root, 2'b01};
            sq_pipe_next[k+1]      = sq_pipe_reg[k];
            sq_pipe_next[k+1].x    = sq_pipe_reg[k].x << 2;
            if (r2 >= t)
            begin
                sq_pipe_next[k+1].rem  = r2 - t;
                sq_pipe_next[k+1].root = {sq_pipe_reg[k].root[RootW-2:0], 1'b1};
            end
            else
            begin
                sq_pipe_next[k+1].rem  = r2;
                sq_pipe_next[k+1].root = {sq_pipe_reg[k].root[RootW-2:0], 1'b0};
            end
        end
    end

    assign m_w    = sq_pipe_reg[SqStages].root;
    assign side_w = sq_pipe_reg[SqStages].side;

    always_comb
    begin
        logic [NumW-1:0] dsh;
        dv_pipe_next[0].den   = m_w;
        dv_pipe_next[0].jac   = side_w.curve ? JacW'(m_w) : JacW'(m_w >> JacShift);
        dv_pipe_next[0].degen = (dv_pipe_next[0].jac == '0);
        dv_pipe_next[0].last  = side_w.last;
        dv_pipe_next[0].neg   = side_w.neg;
        dv_pipe_next[0].quo   = '0;
        for (int i = 0; i < 3; i++)
            dv_pipe_next[0].rem[i] = {side_w.mag[i], {FracW{1'b0}}} + NumW'(m_w >> 1);
        for (int k = 0; k < DvStages; k++)
        begin
            dsh = NumW'(dv_pipe_reg[k].den) << (DvStages - 1 - k);
            dv_pipe_next[k+1] = dv_pipe_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                if (dv_pipe_reg[k].rem[i] >= dsh)
                begin
                    dv_pipe_next[k+1].rem[i] = dv_pipe_reg[k].rem[i] - dsh;
                    dv_pipe_next[k+1].quo[i][DvStages-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]   <= tan0_y * tan1_z;
            p_reg[1]   <= tan0_z * tan1_y;
            p_reg[2]   <= tan0_z * tan1_x;
            p_reg[3]   <= tan0_x * tan1_z;
            p_reg[4]   <= tan0_x * tan1_y;
            p_reg[5]   <= tan0_y * tan1_x;
            ax_reg     <= tan0_x;
            ay_reg     <= tan0_y;
            curve1_reg <= (dims_reg == DimsCurve);
            last1_reg  <= point_is_final;

            s2_reg <= s2_next;

            s3_reg <= s2_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= SumW'(s2_reg.mag[i]) * SumW'(s2_reg.mag[i]);

            sq_pipe_reg[0].x    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sq_pipe_reg[0].rem  <= '0;
            sq_pipe_reg[0].root <= '0;
            sq_pipe_reg[0].side <= s3_reg;
            for (int k = 1; k <= SqStages; k++)
                sq_pipe_reg[k] <= sq_pipe_next[k];

            for (int k = 0; k <= DvStages; k++)
                dv_pipe_reg[k] <= dv_pipe_next[k];

            jac_reg   <= dv_pipe_reg[DvStages].jac;
            degen_reg <= dv_pipe_reg[DvStages].degen;
            last_reg  <= dv_pipe_reg[DvStages].last;
            nx_reg    <= dv_pipe_reg[DvStages].degen ? '0 :
                         (dv_pipe_reg[DvStages].neg[0] ? -NormW'(dv_pipe_reg[DvStages].quo[0])
                                                       : NormW'(dv_pipe_reg[DvStages].quo[0]));
            ny_reg    <= dv_pipe_reg[DvStages].degen ? '0 :
                         (dv_pipe_reg[DvStages].neg[1] ? -NormW'(dv_pipe_reg[DvStages].quo[1])
                                                       : NormW'(dv_pipe_reg[DvStages].quo[1]));
            nz_reg    <= dv_pipe_reg[DvStages].degen ? '0 :
                         (dv_pipe_reg[DvStages].neg[2] ? -NormW'(dv_pipe_reg[DvStages].quo[2])
                                                       : NormW'(dv_pipe_reg[DvStages].quo[2]));
        end
    end

    assign out_valid  = vld_reg[NVld-1];
    assign jacobian   = jac_reg;
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign degenerate = degen_reg;
    assign last_out   = last_reg;

    `SNJ_ASSERT_IMP(a_degen_zero, out_valid && degenerate,
        normal_x == '0 && normal_y == '0 && normal_z == '0, "degenerate result has nonzero normal")
    `SNJ_ASSERT_IMP(a_jac_nonzero, out_valid && !degenerate,
        jacobian != '0, "nondegenerate result has zero jacobian")
    `SNJ_ASSERT_NXT(a_hold_pipe, out_valid && out_stall,
        $stable(vld_reg), "pipeline moved under stall")

endmodule
`default_nettype wire
